>>> rtl/core/mdp_pkg.sv
// shared constants and types for the mdp transition sampler
// no dependencies
package mdp_pkg;
    localparam int NUM_STATES  = 16;
    localparam int NUM_ACTIONS = 4;
    localparam int PROB_BITS   = 16;
    localparam int ST_W  = $clog2(NUM_STATES);
    localparam int ACT_W = $clog2(NUM_ACTIONS);
    localparam int WADDR_W = ST_W + ACT_W + ST_W;
    localparam int CADDR_W = ST_W + ACT_W;
    localparam int SUM_W = PROB_BITS + ST_W;

    localparam logic [2:0] OP_ACTION = 3'd0;
    localparam logic [2:0] OP_WEIGHT = 3'd1;
    localparam logic [2:0] OP_CHANCE = 3'd2;
    localparam logic [2:0] OP_MASK   = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [16:0] ONE_Q = 17'd65536;

    // input item fields
    typedef struct packed {
        logic [15:0] rand_reward;
        logic [15:0] rand_next;
        logic [16:0] table_value;
        logic [3:0]  to_state;
        logic [1:0]  action;
        logic [3:0]  from_state;
        logic [2:0]  opcode;
    } in_item_t;

    // result item fields
    typedef struct packed {
        logic [31:0] total_reward_out;
        logic [31:0] steps_out;
        logic [16:0] reward_out;
        logic [3:0]  current_state_out;
        logic [1:0]  status;
    } out_item_t;
endpackage

>>> rtl/core/mdp_weight_ram.sv
// weight memory, one write and one registered read port
// depends on mdp_pkg
module mdp_weight_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [mdp_pkg::WADDR_W-1:0] waddr,
    input  logic [15:0]                wdata,
    input  logic [mdp_pkg::WADDR_W-1:0] raddr,
    output logic [15:0]                rdata
);
    import mdp_pkg::*;
    logic [15:0] mem [0:(1<<WADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/mdp_transition_sampler.sv
// top level of the mdp transition sampler: sequencer, tables and run state
// depends on mdp_pkg and mdp_weight_ram
//
// Usage:
//   s_axis_* carries one item per transaction (opcode, indexes, table value,
//   two random draws); m_axis_* returns exactly one result per item.
//   cfg_* writes the discount register (Q1.16, values above 1.0 act as 1.0)
//   and may only be used while the block is idle.
// Sequencing:
//   a table write, restart, unknown opcode or illegal action goes from
//   S_IDLE straight to S_OUT, which registers the result and sets m_axis_tvalid.
//   a legal action walks its weight row through the single memory read port
//   twice (total in S_SUM, then selection in S_SEL), reusing one adder/compare,
//   with one multiply for the target in S_MUL and one for the discount in
//   S_DISC, and passes S_FIN, S_DISC and S_OUT; an empty row stops after the
//   first walk and goes from S_MUL to S_OUT.
//   the next item is accepted only once the result has been taken.
//   One item is in flight.
// Reset:
//   aresetn clears run state, masks and discount; weights and chances stay
//   undefined until written.
// Stall:
//   the result is held in an output register until m_axis_tready; the
//   block takes no new item until the result has been taken.
module mdp_transition_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0] from_state[6:3] action[8:7] to_state[12:9]
    // table_value[29:13] rand_next[45:30] rand_reward[61:46]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0] current_state_out[5:2] reward_out[22:6]
    // steps_out[54:23] total_reward_out[86:55]
    output logic [87:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);
    import mdp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DISC  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    in_item_t  item_reg;
    out_item_t res_reg;
    logic [2:0] state_reg;
    logic [ST_W:0] cnt_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] target_reg;
    logic [ST_W-1:0] pick_reg;
    logic found_reg;
    logic [NUM_ACTIONS-1:0] mask_reg [0:NUM_STATES-1];
    logic [16:0] chance_mem [0:(1<<CADDR_W)-1];
    logic [16:0] chance_rd;
    logic [3:0] cur_reg;
    logic [31:0] steps_reg;
    logic [16:0] dmax_reg;
    logic [31:0] total_reg;
    logic [16:0] disc_reg;
    logic [16:0] paid_reg;

    logic [15:0] wr_data;
    logic [WADDR_W-1:0] raddr;
    logic we;
    logic [CADDR_W-1:0] caddr;
    logic [SUM_W-1:0] acc_add;
    logic [SUM_W+15:0] prod_t;
    logic [33:0] prod_d;
    logic [32:0] sum_tot;
    logic s_fire;

    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    assign cfg_ready = 1'b1;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {1'b0, res_reg};

    // weight write straight from the accepted transaction
    assign we = s_fire && (s_axis_tdata[2:0] == OP_WEIGHT);
    assign wr_data = s_axis_tdata[28:13];
    // read address walks the row of the current state and action
    assign raddr = {cur_reg[ST_W-1:0], item_reg.action[ACT_W-1:0], cnt_reg[ST_W-1:0]};
    assign caddr = {cur_reg[ST_W-1:0], item_reg.action[ACT_W-1:0]};

    logic [15:0] w_rd;
    mdp_weight_ram u_wram (
        .aclk  (aclk),
        .we    (we),
        .waddr ({s_axis_tdata[6:3], s_axis_tdata[8:7], s_axis_tdata[12:9]}),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (w_rd)
    );

    // chance table with registered read
    always_ff @(posedge aclk) begin
        if (s_fire && s_axis_tdata[2:0] == OP_CHANCE)
            chance_mem[{s_axis_tdata[6:3], s_axis_tdata[8:7]}] <= s_axis_tdata[29:13];
        chance_rd <= chance_mem[caddr];
    end

    // row adder shared by both walks, target and discount multipliers, total adder
    assign acc_add = acc_reg + {{(SUM_W-16){1'b0}}, w_rd};
    assign prod_t = {{SUM_W{1'b0}}, item_reg.rand_next} * {16'd0, acc_reg};
    assign prod_d = {17'd0, dmax_reg} * {17'd0, (disc_reg > ONE_Q) ? ONE_Q : disc_reg};
    assign sum_tot = {1'b0, total_reg} + {16'd0, paid_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            cur_reg <= '0;
            steps_reg <= '0;
            dmax_reg <= ONE_Q;
            total_reg <= '0;
            disc_reg <= ONE_Q;
            for (int i = 0; i < NUM_STATES; i++) mask_reg[i] <= '0;
        end else begin
            if (cfg_valid) disc_reg <= cfg_data;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        item_reg <= in_item_t'(s_axis_tdata[61:0]);
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        found_reg <= 1'b0;
                        pick_reg <= ST_W'(NUM_STATES-1);
                        paid_reg <= '0;
                        state_reg <= S_OUT;
                        res_reg.status <= ST_OK;
                        unique case (s_axis_tdata[2:0])
                            OP_ACTION: begin
                                if (mask_reg[cur_reg][s_axis_tdata[8:7]]) state_reg <= S_SUM;
                                else res_reg.status <= ST_ILLEGAL;
                            end
                            OP_MASK: mask_reg[s_axis_tdata[6:3]] <=
                                s_axis_tdata[13 +: NUM_ACTIONS];
                            OP_RESTART: begin
                                cur_reg <= '0;
                                steps_reg <= '0;
                                dmax_reg <= ONE_Q;
                                total_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                // data belongs to the previous address, as the read is registered
                S_SUM: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0) acc_reg <= acc_add;
                    if (cnt_reg == (ST_W+1)'(NUM_STATES)) state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (acc_reg == '0) begin
                        res_reg.status <= ST_EMPTY;
                        state_reg <= S_OUT;
                    end else begin
                        target_reg <= SUM_W'(prod_t >> PROB_BITS);
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_add;
                        if (!found_reg && acc_add > target_reg) begin
                            found_reg <= 1'b1;
                            pick_reg <= ST_W'(cnt_reg - 1'b1);
                        end
                    end
                    if (cnt_reg == (ST_W+1)'(NUM_STATES)) state_reg <= S_FIN;
                end
                S_FIN: begin
                    if ({1'b0, item_reg.rand_reward} <= chance_rd) paid_reg <= dmax_reg;
                    steps_reg <= steps_reg + 32'd1;
                    state_reg <= S_DISC;
                end
                S_DISC: begin
                    total_reg <= sum_tot[32] ? 32'hFFFF_FFFF : sum_tot[31:0];
                    dmax_reg <= 17'(prod_d >> PROB_BITS);
                    cur_reg <= pick_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    res_reg.current_state_out <= cur_reg;
                    res_reg.reward_out <= paid_reg;
                    res_reg.steps_out <= steps_reg;
                    res_reg.total_reward_out <= total_reg;
                    m_axis_tvalid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> test/testbench.sv
// self-checking testbench for the mdp transition sampler
// depends on mdp_pkg and the mdp_transition_sampler rtl
module testbench;
    import mdp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int NPAIRS = NUM_STATES * NUM_ACTIONS;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // shadow of the block state
    logic [15:0] mdl_weight [NUM_STATES*NUM_ACTIONS*NUM_STATES];
    logic [16:0] mdl_chance [NPAIRS];
    logic [3:0]  mdl_mask   [NUM_STATES];
    logic [15:0] row_written [NPAIRS];
    logic        chance_written [NPAIRS];
    logic [3:0]  mdl_state;
    logic [31:0] mdl_steps;
    logic [16:0] mdl_dmax;
    logic [31:0] mdl_total;
    logic [16:0] mdl_discount;

    out_item_t   expected_results [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    mdp_transition_sampler u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random back-pressure on the result side
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one result transaction happens at the next edge when both are high here
    always @(negedge aclk) begin
        out_item_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = out_item_t'(m_axis_tdata[86:0]);
            if (expected_results.size() == 0) begin
                $error("result with no expectation: %h", got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("current_state_out", want.current_state_out,
                            got.current_state_out);
                check_field("reward_out", want.reward_out, got.reward_out);
                check_field("steps_out", want.steps_out, got.steps_out);
                check_field("total_reward_out", want.total_reward_out,
                            got.total_reward_out);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endtask

    function automatic void restart_run();
        mdl_state = '0;
        mdl_steps = '0;
        mdl_dmax  = ONE_Q;
        mdl_total = '0;
    endfunction

    // one mdp step and table update, same order as the block
    function automatic out_item_t predict_transition(in_item_t it);
        out_item_t   r;
        int          pair, base;
        logic [19:0] row_sum, run;
        logic [35:0] target;
        logic [3:0]  pick;
        logic [16:0] paid, d;
        logic [32:0] acc;
        logic [33:0] prod;
        logic        found;
        r = '0;
        paid = '0;
        case (it.opcode)
            OP_ACTION: begin
                pair = mdl_state * NUM_ACTIONS + it.action;
                if (!mdl_mask[mdl_state][it.action]) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    base = pair * NUM_STATES;
                    row_sum = '0;
                    for (int k = 0; k < NUM_STATES; k++) row_sum += mdl_weight[base+k];
                    if (row_sum == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        target = (36'(it.rand_next) * row_sum) >> PROB_BITS;
                        pick = 4'(NUM_STATES - 1);
                        run = '0;
                        found = 1'b0;
                        for (int k = 0; k < NUM_STATES; k++) begin
                            run += mdl_weight[base+k];
                            if (!found && 36'(run) > target) begin
                                pick = 4'(k);
                                found = 1'b1;
                            end
                        end
                        mdl_steps++;
                        if (17'(it.rand_reward) <= mdl_chance[pair]) paid = mdl_dmax;
                        acc = 33'(mdl_total) + paid;
                        mdl_total = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                        d = (mdl_discount > ONE_Q) ? ONE_Q : mdl_discount;
                        prod = 34'(mdl_dmax) * d;
                        mdl_dmax = 17'(prod >> PROB_BITS);
                        mdl_state = pick;
                        r.status = ST_OK;
                    end
                end
            end
            OP_WEIGHT: begin
                pair = it.from_state * NUM_ACTIONS + it.action;
                mdl_weight[pair*NUM_STATES + it.to_state] = it.table_value[15:0];
                row_written[pair][it.to_state] = 1'b1;
            end
            OP_CHANCE: begin
                pair = it.from_state * NUM_ACTIONS + it.action;
                mdl_chance[pair] = it.table_value;
                chance_written[pair] = 1'b1;
            end
            OP_MASK:    mdl_mask[it.from_state] = it.table_value[3:0];
            OP_RESTART: restart_run();
            default: ;
        endcase
        r.current_state_out = mdl_state;
        r.reward_out        = paid;
        r.steps_out         = mdl_steps;
        r.total_reward_out  = mdl_total;
        return r;
    endfunction

    // send one input transaction, sometimes with a random gap in front of it
    task automatic send_item(input in_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            repeat ($urandom_range(1, 6)) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it};
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        expected_results.push_back(predict_transition(it));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2*NUM_STATES + 10) @(posedge aclk);
    endtask

    // discount register write, block idle
    task automatic write_discount(input logic [16:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        mdl_discount = value;
    endtask

    function automatic in_item_t make_item(logic [2:0] op, int fs, int act, int ts,
                                           logic [16:0] value, logic [15:0] rn,
                                           logic [15:0] rr);
        in_item_t it;
        it.opcode = op;
        it.from_state = 4'(fs);
        it.action = 2'(act);
        it.to_state = 4'(ts);
        it.table_value = value;
        it.rand_next = rn;
        it.rand_reward = rr;
        return it;
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 17'h0FFFF;
            2: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [15:0] rand_q16();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // whole weight row plus its chance, so the pair may be enabled
    task automatic fill_row(input int fs, input int act, input bit empty_row);
        for (int k = 0; k < NUM_STATES; k++)
            send_item(make_item(OP_WEIGHT, fs, act, k,
                                empty_row ? 17'h10000 : rand_weight(),
                                16'($urandom), 16'($urandom)));
        send_item(make_item(OP_CHANCE, fs, act, 0, 17'($urandom_range(0, 131071)),
                            16'($urandom), 16'($urandom)));
    endtask

    // mask with only fully loaded pairs enabled
    function automatic logic [16:0] safe_mask(int fs, logic [16:0] raw);
        for (int a = 0; a < NUM_ACTIONS; a++)
            if (row_written[fs*NUM_ACTIONS + a] != 16'hFFFF ||
                !chance_written[fs*NUM_ACTIONS + a])
                raw[a] = 1'b0;
        return raw;
    endfunction

    // reset values and operations that touch no table
    task automatic test_reset_state();
        send_item(make_item(OP_ACTION, 0, 0, 0, 0, 16'hFFFF, 0));
        send_item(make_item(OP_ACTION, 15, 3, 15, 17'h1FFFF, 0, 16'hFFFF));
        send_item(make_item(3'd5, 3, 1, 2, 17'h1FFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(3'd6, 0, 0, 0, 0, 0, 0));
        send_item(make_item(3'd7, 15, 3, 15, 17'h1FFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0, 0));
    endtask

    // full-chance rewards, empty row, illegal action
    task automatic test_directed_steps();
        for (int k = 0; k < NUM_STATES; k++)
            send_item(make_item(OP_WEIGHT, 0, 0, k,
                                (k == 15) ? 17'h1FFFF : 17'h10000, 0, 0));
        send_item(make_item(OP_CHANCE, 0, 0, 0, 17'h10000, 0, 0));
        fill_row(0, 1, 1'b1);
        send_item(make_item(OP_CHANCE, 0, 1, 0, 17'h00000, 0, 0));
        send_item(make_item(OP_MASK, 0, 0, 0, 17'h1FFF3, 0, 0));
        send_item(make_item(OP_ACTION, 0, 1, 0, 0, 16'h8000, 0));
        send_item(make_item(OP_ACTION, 0, 2, 0, 0, 0, 0));
        send_item(make_item(OP_ACTION, 0, 0, 0, 0, 0, 16'hFFFF));
        send_item(make_item(OP_ACTION, 0, 0, 0, 0, 16'hFFFF, 0));
        send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_ACTION, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0, 0));
    endtask

    // mostly loaded rows and walks, some noise
    task automatic test_random_walk(input int item_goal, input bit hold_off);
        int sent, sel, fs;
        sent = 0;
        while (sent < item_goal) begin
            sel = $urandom_range(0, 99);
            fs = $urandom_range(0, NUM_STATES-1);
            if (sel < 6) begin
                fill_row(fs, $urandom_range(0, 3), ($urandom_range(0, 7) == 0));
                sent += NUM_STATES + 1;
            end else begin
                if (sel < 60)
                    send_item(make_item(OP_ACTION, $urandom_range(0, 15), $urandom_range(0, 3),
                                        $urandom_range(0, 15), 17'($urandom),
                                        rand_q16(), rand_q16()));
                else if (sel < 70)
                    send_item(make_item(OP_MASK, fs, 0, 0,
                                        safe_mask(fs, 17'($urandom)), 0, 0));
                else if (sel < 80)
                    send_item(make_item(OP_WEIGHT, fs, $urandom_range(0, 3),
                                        $urandom_range(0, 15), rand_weight(),
                                        16'($urandom), 16'($urandom)));
                else if (sel < 86)
                    send_item(make_item(OP_CHANCE, fs, $urandom_range(0, 3), 0,
                                        17'($urandom_range(0, 131071)), 0, 0));
                else if (sel < 93)
                    send_item(make_item(OP_RESTART, fs, 0, 0, 17'($urandom), 0, 0));
                else
                    send_item(make_item(3'($urandom_range(5, 7)), fs, $urandom_range(0, 3),
                                        $urandom_range(0, 15), 17'($urandom),
                                        16'($urandom), 16'($urandom)));
                sent++;
            end
            if (hold_off && sent == item_goal / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_results.size() != 0) @(posedge aclk);
            end
        end
    endtask

    initial begin
        send_idle_pct = 34;
        recv_idle_pct = 54;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < NUM_STATES*NUM_ACTIONS*NUM_STATES; i++) mdl_weight[i] = '0;
        for (int i = 0; i < NPAIRS; i++) begin
            mdl_chance[i] = '0;
            row_written[i] = '0;
            chance_written[i] = 1'b0;
        end
        for (int i = 0; i < NUM_STATES; i++) mdl_mask[i] = '0;
        mdl_discount = ONE_Q;
        restart_run();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_directed_steps();
        write_discount(17'd0);
        test_random_walk(150, 1'b0);
        write_discount(17'h1FFFF);
        test_random_walk(150, 1'b1);

        send_idle_pct = 54;
        recv_idle_pct = 34;
        write_discount(17'd60000);
        test_random_walk(300, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_discount(17'($urandom_range(0, 65536)));
        test_random_walk(150, 1'b0);
        write_discount(ONE_Q);
        test_random_walk(150, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> mdp_transition_sampler.f
rtl/core/mdp_pkg.sv
rtl/core/mdp_weight_ram.sv
rtl/core/mdp_transition_sampler.sv
test/testbench.sv
